>>> design/esflr_pkg.sv
// shared types, codes and constants of the escape/start/length frame receiver
package esflr_pkg;

   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 9;
   localparam int STATUS_W   = 3;
   localparam int LEN_W      = 9;
   localparam int TICK_W     = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam int DEFAULT_BUFFER_DEPTH = 512;

   // operation codes
   localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
   localparam logic [OP_W-1:0] OP_IDLE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FIXED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_LIMIT = 2'd3;

   localparam logic [BYTE_W-1:0] RST_ESCAPE     = 8'd27;
   localparam logic [BYTE_W-1:0] RST_START      = 8'd2;
   localparam logic [BYTE_W-1:0] RST_END        = 8'd3;
   localparam logic [TICK_W-1:0] RST_IDLE_LIMIT = 16'd10000;

   // frame layout
   localparam logic [LEN_W-1:0]  LEN_BIAS   = 9'd9;
   localparam logic [BYTE_W-1:0] GHOST_TYPE = 8'h06;
   localparam logic [IDX_W-1:0]  TYPE_POS   = 9'd2;
   localparam logic [IDX_W-1:0]  LEN_POS    = 9'd5;
   localparam logic [IDX_W-1:0]  GHOST_POS  = 9'd6;
   localparam logic [IDX_W-1:0]  BODY_POS   = 9'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] escape;
      logic [BYTE_W-1:0] start_code;
      logic [BYTE_W-1:0] end_code;
      logic [TICK_W-1:0] idle_limit;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              sweep_go;
      logic [LEN_W-1:0]  sweep_last;
   } store_cmd_type;

endpackage

>>> design/esflr_req_if.sv
// request channel: op, received byte and read offset
interface esflr_req_if import esflr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [BYTE_W-1:0] rx_byte;
   logic [IDX_W-1:0]  read_index;

   modport source (output valid, output op, output rx_byte, output read_index, input ready);
   modport sink   (input valid, input op, input rx_byte, input read_index, output ready);
endinterface

>>> design/esflr_rsp_if.sv
// response channel: status, frame length and read data
interface esflr_rsp_if import esflr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    frame_length;
   logic [BYTE_W-1:0]   read_data;

   modport source (output valid, output status, output frame_length, output read_data,
                   input ready);
   modport sink   (input valid, input status, input frame_length, input read_data,
                   output ready);
endinterface

>>> design/esflr_csr.sv
// configuration registers behind the apb-style port
module esflr_csr import esflr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   logic                   wr_en;
   logic [CSR_IDX_W-1:0]   reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape     <= RST_ESCAPE;
         cfg_ff.start_code <= RST_START;
         cfg_ff.end_code   <= RST_END;
         cfg_ff.idle_limit <= RST_IDLE_LIMIT;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_ESCAPE:     cfg_ff.escape     <= pwdata[BYTE_W-1:0];
            REG_START:      cfg_ff.start_code <= pwdata[BYTE_W-1:0];
            REG_END:        cfg_ff.end_code   <= pwdata[BYTE_W-1:0];
            REG_IDLE_LIMIT: cfg_ff.idle_limit <= pwdata[TICK_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ESCAPE:     prdata = CSR_DATA_W'(cfg_ff.escape);
         REG_START:      prdata = CSR_DATA_W'(cfg_ff.start_code);
         REG_END:        prdata = CSR_DATA_W'(cfg_ff.end_code);
         REG_IDLE_LIMIT: prdata = CSR_DATA_W'(cfg_ff.idle_limit);
      endcase
   end

endmodule

>>> design/esflr_store.sv
// frame store memory with the ghost-byte shift sweep
module esflr_store import esflr_pkg::*; #(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  store_cmd_type     cmd,
   output logic [BYTE_W-1:0] rd_data,
   output logic              busy
);

   localparam int AW = $clog2(BUFFER_DEPTH);

   logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic              sweep_active_ff, sweep_active_in;
   logic [IDX_W-1:0]  sweep_ptr_ff, sweep_ptr_in;
   logic [LEN_W-1:0]  sweep_last_ff, sweep_last_in;
   logic              copy_pend_ff, copy_pend_in;
   logic [IDX_W-1:0]  copy_addr_ff, copy_addr_in;

   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;

   assign busy    = sweep_active_ff | copy_pend_ff;
   assign rd_data = rd_data_ff;

   // sweep reads offset j+1 and writes it back to offset j in the next cycle
   always_comb begin
      sweep_active_in = sweep_active_ff;
      sweep_ptr_in    = sweep_ptr_ff;
      sweep_last_in   = sweep_last_ff;
      copy_pend_in    = 1'b0;
      copy_addr_in    = copy_addr_ff;
      if (cmd.sweep_go) begin
         sweep_active_in = 1'b1;
         sweep_ptr_in    = GHOST_POS + IDX_W'(1);
         sweep_last_in   = cmd.sweep_last;
      end else if (sweep_active_ff) begin
         sweep_ptr_in = sweep_ptr_ff + IDX_W'(1);
         copy_pend_in = 1'b1;
         copy_addr_in = sweep_ptr_ff - IDX_W'(1);
         if (LEN_W'(sweep_ptr_ff) == sweep_last_ff) begin
            sweep_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      mem_rd_en   = sweep_active_ff | cmd.rd_en;
      mem_rd_addr = sweep_active_ff ? AW'(sweep_ptr_ff) : AW'(cmd.rd_addr);
      mem_wr_en   = copy_pend_ff | cmd.wr_en;
      mem_wr_addr = copy_pend_ff ? AW'(copy_addr_ff) : AW'(cmd.wr_addr);
      mem_wr_data = copy_pend_ff ? rd_data_ff : cmd.wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b0;
         copy_pend_ff    <= 1'b0;
      end else begin
         sweep_active_ff <= sweep_active_in;
         copy_pend_ff    <= copy_pend_in;
      end
      sweep_ptr_ff  <= sweep_ptr_in;
      sweep_last_ff <= sweep_last_in;
      copy_addr_ff  <= copy_addr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

endmodule

>>> design/esflr_ctrl.sv
// framing state, request decode and the two-stage response path
module esflr_ctrl import esflr_pkg::*; #(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   esflr_req_if.sink         req,
   esflr_rsp_if.source       rsp,
   output store_cmd_type     store_cmd,
   input  logic [BYTE_W-1:0] store_rd_data,
   input  logic              store_busy
);

   // framing state
   logic              collecting_ff, collecting_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [BYTE_W-1:0] prev_byte_ff, prev_byte_in;
   logic [IDX_W-1:0]  write_pos_ff, write_pos_in;
   logic [TICK_W-1:0] idle_count_ff, idle_count_in;
   logic              ghost_ff, ghost_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] hdr0_ff, hdr0_in;
   logic [BYTE_W-1:0] hdr1_ff, hdr1_in;

   // response stage and output register
   logic                s1_valid_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   logic [LEN_W-1:0]    s1_len_ff;
   logic [BYTE_W-1:0]   s1_byte_ff;
   logic                s1_from_mem_ff;
   logic                out_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [LEN_W-1:0]    out_len_ff;
   logic [BYTE_W-1:0]   out_data_ff;

   logic                accept, out_free, s1_move;
   logic [STATUS_W-1:0] res_status;
   logic [LEN_W-1:0]    res_len;
   logic [BYTE_W-1:0]   res_byte;
   logic                res_from_mem;
   logic [IDX_W-1:0]    pos;
   logic                end_match;
   logic [TICK_W-1:0]   idle_next, idle_lim;
   store_cmd_type       cmd;

   assign out_free  = ~out_valid_ff | rsp.ready;
   assign s1_move   = s1_valid_ff & out_free;
   assign req.ready = ~store_busy & (~s1_valid_ff | out_free);
   assign accept    = req.valid & req.ready;

   assign pos       = write_pos_ff + IDX_W'(1);
   assign end_match = (prev_byte_ff == cfg.escape) & (req.rx_byte == cfg.end_code);
   assign idle_next = idle_count_ff + TICK_W'(1);
   assign idle_lim  = (cfg.idle_limit == '0) ? TICK_W'(1) : cfg.idle_limit;

   always_comb begin
      collecting_in = collecting_ff;
      prev_valid_in = prev_valid_ff;
      prev_byte_in  = prev_byte_ff;
      write_pos_in  = write_pos_ff;
      idle_count_in = idle_count_ff;
      ghost_in      = ghost_ff;
      len_in        = len_ff;
      hdr0_in       = hdr0_ff;
      hdr1_in       = hdr1_ff;
      res_status    = ST_NONE;
      res_len       = '0;
      res_byte      = '0;
      res_from_mem  = 1'b0;
      cmd           = '0;

      unique case (req.op)
         OP_BYTE: begin
            if (!collecting_ff) begin
               if (prev_valid_ff && prev_byte_ff == cfg.escape &&
                   req.rx_byte == cfg.start_code) begin
                  hdr0_in       = cfg.escape;
                  hdr1_in       = cfg.start_code;
                  write_pos_in  = BODY_POS;
                  collecting_in = 1'b1;
                  prev_valid_in = 1'b0;
                  idle_count_in = '0;
               end else begin
                  prev_byte_in  = req.rx_byte;
                  prev_valid_in = 1'b1;
               end
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_addr  = write_pos_ff;
               cmd.wr_data  = req.rx_byte;
               write_pos_in = pos;
               prev_byte_in = req.rx_byte;
               if (write_pos_ff == TYPE_POS) begin
                  ghost_in = (req.rx_byte == GHOST_TYPE);
               end
               if (write_pos_ff == LEN_POS) begin
                  len_in = LEN_W'(req.rx_byte) + LEN_BIAS;
               end
               // len_ff is at least the bias, so this never fires before offset 5
               if (LEN_W'(pos) >= len_ff) begin
                  if (LEN_W'(pos) == len_ff) begin
                     if (end_match) begin
                        res_status = ST_OK;
                        res_len    = len_ff;
                     end else if (!ghost_ff) begin
                        res_status = ST_BAD;
                     end
                  end else if (end_match) begin
                     // ghost byte at offset 6: shift the body down by one
                     res_status     = ST_FIXED;
                     res_len        = len_ff;
                     cmd.sweep_go   = 1'b1;
                     cmd.sweep_last = len_ff;
                  end else begin
                     res_status = ST_BAD;
                  end
                  if (res_status != ST_NONE) begin
                     collecting_in = 1'b0;
                     prev_valid_in = 1'b0;
                     prev_byte_in  = '0;
                     idle_count_in = '0;
                  end
               end
            end
         end
         OP_IDLE: begin
            if (idle_next >= idle_lim) begin
               res_status    = ST_TIMEOUT;
               collecting_in = 1'b0;
               prev_valid_in = 1'b0;
               prev_byte_in  = '0;
               idle_count_in = '0;
            end else begin
               idle_count_in = idle_next;
            end
         end
         OP_READ: begin
            if (req.read_index == IDX_W'(0)) begin
               res_byte = hdr0_ff;
            end else if (req.read_index == IDX_W'(1)) begin
               res_byte = hdr1_ff;
            end else if (32'(req.read_index) < BUFFER_DEPTH) begin
               cmd.rd_en    = 1'b1;
               cmd.rd_addr  = req.read_index;
               res_from_mem = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign store_cmd = accept ? cmd : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
         prev_byte_ff  <= '0;
         write_pos_ff  <= '0;
         idle_count_ff <= '0;
         ghost_ff      <= 1'b0;
         len_ff        <= LEN_BIAS;
      end else if (accept) begin
         collecting_ff <= collecting_in;
         prev_valid_ff <= prev_valid_in;
         prev_byte_ff  <= prev_byte_in;
         write_pos_ff  <= write_pos_in;
         idle_count_ff <= idle_count_in;
         ghost_ff      <= ghost_in;
         len_ff        <= len_in;
      end
      if (accept) begin
         hdr0_ff <= hdr0_in;
         hdr1_ff <= hdr1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         s1_status_ff   <= res_status;
         s1_len_ff      <= res_len;
         s1_byte_ff     <= res_byte;
         s1_from_mem_ff <= res_from_mem;
      end
      // memory read data lines up with the stage after the accept
      if (s1_move) begin
         out_status_ff <= s1_status_ff;
         out_len_ff    <= s1_len_ff;
         out_data_ff   <= s1_from_mem_ff ? store_rd_data : s1_byte_ff;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_status_ff;
   assign rsp.frame_length = out_len_ff;
   assign rsp.read_data    = out_data_ff;

endmodule

>>> design/esc_stx_length_frame_receiver.sv
// top level of the escape/start/length frame receiver
//
//   port        dir   carries                               accepted when
//   req_ch      in    op, rx_byte, read_index              valid && ready
//   rsp_ch      out   status, frame_length, read_data      valid && ready
//   csr_*       in    escape, start, end, idle limit regs  psel && penable && pwrite
//
// one word per cycle in and out when not stalled; responses pass the s1 and output registers
// a repaired frame of length L holds req_ch.ready low while the store
// port shifts offsets 7..L down by one (L-6 reads plus a trailing write)
// reset is synchronous; the frame store is not cleared, reads of unwritten offsets are
// undefined; rsp_ch stalls back up through one stage, then drop req_ch.ready
module esc_stx_length_frame_receiver import esflr_pkg::*; #(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   esflr_req_if.sink             req_ch,
   esflr_rsp_if.source           rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type           cfg;
   store_cmd_type     store_cmd;
   logic [BYTE_W-1:0] store_rd_data;
   logic              store_busy;

   esflr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   esflr_store #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_data (store_rd_data),
      .busy    (store_busy)
   );

   esflr_ctrl #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .store_cmd     (store_cmd),
      .store_rd_data (store_rd_data),
      .store_busy    (store_busy)
   );

endmodule

>>> design/esflr_checker.sv
// port-level checks for the frame receiver, bound to the top level
module esflr_checker import esflr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [LEN_W-1:0]    rsp_frame_length,
   input logic [BYTE_W-1:0]   rsp_read_data
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_frame_length) && $stable(rsp_read_data))
      else $error("response word changed while stalled");

   // every new response comes from an earlier accepted request word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

   // length only for good or repaired frames, and within the header range
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_length != '0 |->
      (rsp_status == ST_OK || rsp_status == ST_FIXED) &&
      rsp_frame_length >= LEN_BIAS && rsp_frame_length <= LEN_BIAS + LEN_W'(255))
      else $error("frame length out of place");

   // read data only on plain read responses
   a_data_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != '0 |-> rsp_status == ST_NONE && rsp_frame_length == '0)
      else $error("read data on a frame event");

endmodule

bind esc_stx_length_frame_receiver esflr_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_frame_length (rsp_ch.frame_length),
   .rsp_read_data    (rsp_ch.read_data)
);

>>> sim/frame_rx_checker.sv
// watches the request, response and register ports, predicts every response and compares
module frame_rx_checker import esflr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   esflr_req_if                  req_ch,
   esflr_rsp_if                  rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatch_count,
   output int                    words_due,
   output int                    stored_extent
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = DEFAULT_BUFFER_DEPTH;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    frame_length;
      logic [BYTE_W-1:0]   read_data;
   } rx_outcome_t;

   cfg_type           rx_cfg;
   bit                in_frame;
   bit                have_prev;
   logic [BYTE_W-1:0] last_byte;
   int unsigned       wpos;
   logic [TICK_W-1:0] ticks;
   bit                ghost_fixed;
   logic [BYTE_W-1:0] store [STORE_DEPTH];
   int                written_top;
   int                errs = 0;
   int                rsp_seen = 0;
   rx_outcome_t       outcomes_due[$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s of response %0d: got %0d, expected %0d", what, rsp_seen, got,
               want);
      errs++;
   endtask

   function automatic void return_to_hunt();
      in_frame  = 1'b0;
      have_prev = 1'b0;
      last_byte = '0;
      ticks     = '0;
   endfunction

   function automatic rx_outcome_t predict_outcome(input logic [OP_W-1:0] op,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [IDX_W-1:0] idx);
      rx_outcome_t r;
      int unsigned flen;
      int unsigned lim;
      r = '0;
      case (op)
         OP_BYTE: begin
            if (!in_frame) begin
               if (have_prev && last_byte == rx_cfg.escape && b == rx_cfg.start_code) begin
                  store[0]    = rx_cfg.escape;
                  store[1]    = rx_cfg.start_code;
                  wpos        = 2;
                  in_frame    = 1'b1;
                  have_prev   = 1'b0;
                  ticks       = '0;
                  ghost_fixed = 1'b0;
                  if (written_top < 2) written_top = 2;
               end else begin
                  last_byte = b;
                  have_prev = 1'b1;
               end
            end else begin
               store[wpos] = b;
               wpos++;
               if (wpos > written_top) written_top = wpos;
               if (wpos > LEN_POS) begin
                  flen = store[LEN_POS] + LEN_BIAS;
                  if (wpos >= flen) begin
                     if (store[flen-2] == rx_cfg.escape && store[flen-1] == rx_cfg.end_code) begin
                        r.status       = ST_OK;
                        r.frame_length = LEN_W'(flen);
                        return_to_hunt();
                     end else if (store[TYPE_POS] == GHOST_TYPE && wpos == flen) begin
                        // one extra byte may still close a frame with a ghost byte
                     end else if (store[TYPE_POS] == GHOST_TYPE &&
                                  store[flen-1] == rx_cfg.escape &&
                                  store[flen] == rx_cfg.end_code) begin
                        for (int j = GHOST_POS; j < flen; j++) store[j] = store[j+1];
                        ghost_fixed    = 1'b1;
                        r.status       = ST_FIXED;
                        r.frame_length = LEN_W'(flen);
                        return_to_hunt();
                     end else begin
                        r.status = ST_BAD;
                        return_to_hunt();
                     end
                  end
               end
            end
         end
         OP_IDLE: begin
            lim   = (rx_cfg.idle_limit == '0) ? 1 : rx_cfg.idle_limit;
            ticks = ticks + 1'b1;
            if (ticks >= lim) begin
               r.status = ST_TIMEOUT;
               return_to_hunt();
            end
         end
         OP_READ: r.read_data = store[idx];
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rx_outcome_t want;
      if (reset) begin
         rx_cfg = '{escape: RST_ESCAPE, start_code: RST_START, end_code: RST_END,
                    idle_limit: RST_IDLE_LIMIT};
         return_to_hunt();
         wpos        = 0;
         ghost_fixed = 1'b0;
         written_top = 0;
         outcomes_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (outcomes_due.size() == 0) begin
               report_mismatch("status (none expected)", rsp_ch.status, 0);
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", rsp_ch.status, want.status);
               if (rsp_ch.frame_length !== want.frame_length)
                  report_mismatch("frame_length", rsp_ch.frame_length, want.frame_length);
               if (rsp_ch.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_ch.read_data, want.read_data);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_ESCAPE:     rx_cfg.escape     = csr_pwdata[BYTE_W-1:0];
               REG_START:      rx_cfg.start_code = csr_pwdata[BYTE_W-1:0];
               REG_END:        rx_cfg.end_code   = csr_pwdata[BYTE_W-1:0];
               REG_IDLE_LIMIT: rx_cfg.idle_limit = csr_pwdata[TICK_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            outcomes_due.push_back(predict_outcome(req_ch.op, req_ch.rx_byte, req_ch.read_index));
      end
      mismatch_count <= errs;
      words_due      <= outcomes_due.size();
      stored_extent  <= written_top;
   end
endmodule

>>> sim/testbench.sv
// top of the frame receiver testbench: clock, reset, stimulus, receiver stalls and verdict
module testbench import esflr_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_CYCLES     = 200;
   localparam int SETTLE_CYCLES   = 300;
   localparam int WORDS_PER_PHASE = 340;
   localparam int N_PHASES        = 5;
   localparam int TIMEOUT_NS      = 2_000_000;

   typedef enum int {FRAME_OK, FRAME_FIXED, FRAME_BAD, FRAME_CUT} frame_kind_e;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    words_due;
   int                    stored_extent;
   logic                  no_gaps = 1'b0;
   int                    hold_requests = 0;
   int                    words_sent = 0;
   cfg_type               active_cfg;
   cfg_type               phase_cfg [N_PHASES];

   esflr_req_if req_ch();
   esflr_rsp_if rsp_ch();

   esc_stx_length_frame_receiver i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_rx_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (fail_count),
      .words_due      (words_due),
      .stored_extent  (stored_extent)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("testbench failed");
      $finish;
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int holds_served;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 32);
         end
      end
   end

   task automatic put_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                           input logic [IDX_W-1:0] idx);
      while (!no_gaps && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.rx_byte    <= b;
      req_ch.read_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // byte stream, optionally mixed with idle ticks, reads and unused ops
   task automatic play_bytes(input logic [BYTE_W-1:0] bytes[$], input bit mixed);
      foreach (bytes[i]) begin
         while (mixed && $urandom_range(99) < 8) begin
            case ($urandom_range(9))
               0: put_word(OP_UNUSED, BYTE_W'($urandom), IDX_W'($urandom));
               1, 2, 3, 4: begin
                  if (stored_extent > 0)
                     put_word(OP_READ, BYTE_W'($urandom),
                              IDX_W'($urandom_range(stored_extent - 1)));
                  else
                     put_word(OP_IDLE, BYTE_W'($urandom), IDX_W'($urandom));
               end
               default: put_word(OP_IDLE, BYTE_W'($urandom), IDX_W'($urandom));
            endcase
         end
         put_word(OP_BYTE, bytes[i], IDX_W'($urandom));
      end
   endtask

   task automatic send_frame(input int len_field, input frame_kind_e kind);
      logic [BYTE_W-1:0] bytes[$];
      int flen;
      int noise;
      flen  = len_field + LEN_BIAS;
      noise = $urandom_range(2);
      repeat (noise) bytes.push_back(BYTE_W'($urandom));
      bytes.push_back(active_cfg.escape);
      bytes.push_back(active_cfg.start_code);
      if (kind == FRAME_FIXED || $urandom_range(3) == 0)
         bytes.push_back(GHOST_TYPE);
      else
         bytes.push_back(BYTE_W'($urandom));
      bytes.push_back(BYTE_W'($urandom));
      bytes.push_back(BYTE_W'($urandom));
      bytes.push_back(BYTE_W'(len_field));
      for (int i = GHOST_POS; i < flen - 2; i++) bytes.push_back(BYTE_W'($urandom));
      bytes.push_back(active_cfg.escape);
      bytes.push_back(active_cfg.end_code);
      case (kind)
         FRAME_FIXED: bytes.insert(noise + int'(GHOST_POS), BYTE_W'($urandom));
         FRAME_BAD:   bytes[bytes.size()-1] = bytes[bytes.size()-1] ^
                                              BYTE_W'($urandom_range(1, 255));
         FRAME_CUT:   repeat ($urandom_range(1, flen - 3)) void'(bytes.pop_back());
         default: ;
      endcase
      play_bytes(bytes, 1'b1);
   endtask

   initial begin
      logic [BYTE_W-1:0] frame[$];
      frame_kind_e       kind;
      int                phase_end;
      int                n;

      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.op         <= OP_BYTE;
      req_ch.rx_byte    <= '0;
      req_ch.read_index <= '0;
      active_cfg = '{escape: RST_ESCAPE, start_code: RST_START, end_code: RST_END,
                     idle_limit: RST_IDLE_LIMIT};
      phase_cfg[0] = '{escape: 8'h00, start_code: 8'hFF, end_code: 8'h00, idle_limit: 16'd1};
      phase_cfg[1] = '{escape: 8'hFF, start_code: 8'h00, end_code: 8'hFF,
                       idle_limit: 16'd65535};
      phase_cfg[2] = '{escape: 8'h7E, start_code: 8'h7E, end_code: 8'h7E, idle_limit: 16'd25};
      phase_cfg[3] = '{escape: BYTE_W'($urandom), start_code: BYTE_W'($urandom),
                       end_code: BYTE_W'($urandom), idle_limit: TICK_W'($urandom_range(2, 60))};
      phase_cfg[4] = '{escape: RST_ESCAPE, start_code: RST_START, end_code: RST_END,
                       idle_limit: 16'd12};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: unused op, idle tick, shortest ok frame, reads, frame with a ghost byte
      put_word(OP_UNUSED, 8'hFF, 9'h1FF);
      put_word(OP_IDLE, 8'h00, 9'h000);
      frame = '{RST_ESCAPE, RST_START, 8'h00, 8'hAA, 8'h55, 8'h00, 8'hFF, RST_ESCAPE, RST_END};
      play_bytes(frame, 1'b0);
      put_word(OP_READ, 8'h00, 9'd0);
      put_word(OP_READ, 8'hFF, 9'd8);
      frame = '{RST_ESCAPE, RST_START, GHOST_TYPE, 8'h11, 8'h22, 8'h00, 8'h99, 8'h44,
                RST_ESCAPE, RST_END};
      play_bytes(frame, 1'b0);
      put_word(OP_READ, 8'h5A, GHOST_POS);

      for (int p = 0; p < N_PHASES; p++) begin
         drain_results();
         // a repaired frame may still be shifting after its response
         repeat (SETTLE_CYCLES) @(posedge clock);
         active_cfg = phase_cfg[p];
         csr_write(REG_ESCAPE, CSR_DATA_W'(active_cfg.escape));
         csr_write(REG_START, CSR_DATA_W'(active_cfg.start_code));
         csr_write(REG_END, CSR_DATA_W'(active_cfg.end_code));
         csr_write(REG_IDLE_LIMIT, CSR_DATA_W'(active_cfg.idle_limit));
         no_gaps <= (p == 2);
         phase_end = words_sent + WORDS_PER_PHASE;
         n = 0;
         while (words_sent < phase_end) begin
            n++;
            case ($urandom_range(9))
               0, 1, 2, 3, 4: kind = FRAME_OK;
               5, 6, 7:       kind = FRAME_FIXED;
               8:             kind = FRAME_BAD;
               default:       kind = FRAME_CUT;
            endcase
            if (p == 1 && n == 1)
               send_frame(255, FRAME_OK);
            else if (p == 1 && n == 2)
               send_frame(255, FRAME_FIXED);
            else if ($urandom_range(19) == 0)
               send_frame($urandom_range(13, 255), kind);
            else
               send_frame($urandom_range(12), kind);
            if (p == 0 && n == 6) drain_results();
            if (p == 3 && n == 4) hold_requests <= hold_requests + 1;
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule
